// ----- rtl/bsfcrc_pkg.sv -----
`default_nettype none
package bsfcrc_pkg;

    // Phase codes of the deframer; codes 5 to 7 behave as idle.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_DATA = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_CRCL = 3'd3;
    localparam logic [2:0] PH_CRCH = 3'd4;

    // Line codes.
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_MASK  = 8'h20;

    // CRC-16, MSB first.
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_GOOD  = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  count;
        logic [15:0] crc;
        logic [7:0]  crc_low;
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] index;
    } t_result;

    // One byte through the CRC, eight unrolled shift steps.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/byte_stuffed_frame_crc_receiver_core.sv -----
`default_nettype none
// Byte-stuffed frame receiver with CRC-16 check.
// Input channel (i_in_valid / o_in_ready / i_line_byte) takes one raw line
// byte per item. Output channel (o_out_valid / i_out_ready) gives one result
// item: kind, decoded payload byte and its index within the frame.
// Bytes are ignored until a 0x7E flag; then FRAME_BYTES payload bytes are
// unstuffed (0x7D escapes the next byte, XOR 0x20), then two raw CRC bytes,
// low first, give a good or bad verdict. A flag inside the payload yields an
// abort item and restarts the frame.
// An accepted item sits in the input register, and its result, if any, is
// computed combinationally and shown from the output register.
// Throughput: one item per cycle unless the output stalls; the CRC byte
// update is combinational, between the input and the result registers.
// A stalled output holds the result and the input register; o_in_ready then
// stays high only while the held input byte makes no result or the input
// register is empty.
// Reset (synchronous, active low) clears both valid flags and returns the
// deframer to idle with the CRC at 0xFFFF.
module byte_stuffed_frame_crc_receiver_core #(
    parameter int FRAME_BYTES = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_line_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_payload_byte,
    output logic [7:0]      o_byte_index
);
    import bsfcrc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_result    step_result;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_data;
    logic [7:0] r_index;
    logic       out_free;
    logic       advance;

    bsfcrc_decode #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_decode (
        .i_state    (r_state),
        .i_line_byte(r_in_byte),
        .o_state    (n_state),
        .o_result   (step_result)
    );

    // Advance the held byte when its result, if any, has a place to go.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (out_free || !step_result.valid);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_line_byte;
        end
    end

    // Deframer state moves only when the held byte is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase   <= PH_IDLE;
            r_state.count   <= '0;
            r_state.crc     <= CRC_INIT;
            r_state.crc_low <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register: load a new result, or drop the taken one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && step_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && advance && step_result.valid) begin
            r_kind  <= step_result.kind;
            r_data  <= step_result.data;
            r_index <= step_result.index;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_payload_byte = r_data;
    assign o_byte_index   = r_index;

endmodule
`default_nettype wire

// ----- rtl/bsfcrc_decode.sv -----
`default_nettype none
module bsfcrc_decode #(
    parameter int FRAME_BYTES = 16
) (
    input  wire bsfcrc_pkg::t_state  i_state,
    input  wire logic [7:0]          i_line_byte,
    output bsfcrc_pkg::t_state       o_state,
    output bsfcrc_pkg::t_result      o_result
);
    import bsfcrc_pkg::*;

    localparam logic [8:0] LastCount = 9'(FRAME_BYTES);

    logic [7:0]  data_byte;
    logic [15:0] crc_next;
    logic [8:0]  count_inc;
    logic [15:0] crc_final;

    assign data_byte = (i_state.phase == PH_ESC) ? (i_line_byte ^ ESC_MASK) : i_line_byte;
    assign crc_next  = crc_feed(i_state.crc, data_byte);
    assign count_inc = {1'b0, i_state.count} + 9'd1;
    assign crc_final = i_state.crc ^ CRC_XOROUT;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (i_state.phase)
            PH_DATA, PH_ESC: begin
                if (i_state.phase == PH_DATA && i_line_byte == FLAG_BYTE) begin
                    // abort and restart at once
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_ABORT;
                    o_state.phase  = PH_DATA;
                    o_state.count  = '0;
                    o_state.crc    = CRC_INIT;
                end else if (i_state.phase == PH_DATA && i_line_byte == ESC_BYTE) begin
                    o_state.phase = PH_ESC;
                end else begin
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_BYTE;
                    o_result.data  = data_byte;
                    o_result.index = i_state.count;
                    o_state.crc    = crc_next;
                    if (count_inc >= LastCount) begin
                        o_state.phase = PH_CRCL;
                        o_state.count = '0;
                    end else begin
                        o_state.phase = PH_DATA;
                        o_state.count = count_inc[7:0];
                    end
                end
            end
            PH_CRCL: begin
                o_state.crc_low = i_line_byte;
                o_state.phase   = PH_CRCH;
            end
            PH_CRCH: begin
                o_result.valid = 1'b1;
                o_result.kind  = (crc_final == {i_line_byte, i_state.crc_low}) ? KIND_GOOD
                                                                               : KIND_BAD;
                o_state.phase  = PH_IDLE;
                o_state.count  = '0;
                o_state.crc    = CRC_INIT;
            end
            default: begin
                if (i_line_byte == FLAG_BYTE) begin
                    o_state.phase = PH_DATA;
                    o_state.count = '0;
                    o_state.crc   = CRC_INIT;
                end else begin
                    o_state.phase = PH_IDLE;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- verif/tb_byte_stuffed_frame_crc_receiver_core.sv -----
`timescale 1ns / 100ps

module tb_byte_stuffed_frame_crc_receiver_core;
    import bsfcrc_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int FRAME_LEN   = 16;
    // Bytes that reach the deframer (idle bytes it drops are not counted).
    localparam int ITEM_TARGET = 1600;
    // Input register plus output register, with some margin.
    localparam int SETTLE_CYCLES = 4;
    localparam int TIMEOUT_NS    = 8_000_000;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] index;
    } t_rx_result;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_line_byte    = 8'h00;
    logic       i_out_ready    = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_payload_byte;
    logic [7:0] o_byte_index;

    // Deframer state as the testbench sees it.
    logic [2:0]  rx_phase;
    logic [7:0]  rx_count;
    logic [15:0] rx_crc;
    logic [7:0]  rx_crc_low;

    // Results still owed by the block, oldest first.
    t_rx_result frame_events_due[$];

    int  mismatches  = 0;
    int  frame_items = 0;
    // Set to run both sides back to back with no idle cycles.
    bit  steady_flow = 1'b0;

    byte_stuffed_frame_crc_receiver_core #(
        .FRAME_BYTES(FRAME_LEN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_line_byte    (i_line_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // CRC-16 (poly 0x1021, MSB first), one message bit per shift.
    function automatic logic [15:0] crc16_shift_byte(input logic [15:0] c,
                                                     input logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Restart collection: count back to zero, CRC back to its seed.
    function automatic void open_frame();
        rx_phase = PH_DATA;
        rx_count = 8'h00;
        rx_crc   = CRC_INIT;
    endfunction

    // Report one decoded byte, fold it into the CRC and advance the count.
    function automatic bit take_payload(input logic [7:0] d, output t_rx_result r);
        r.kind  = KIND_BYTE;
        r.data  = d;
        r.index = rx_count;
        rx_crc  = crc16_shift_byte(rx_crc, d);
        if (int'(rx_count) + 1 >= FRAME_LEN) begin
            rx_phase = PH_CRCL;
            rx_count = 8'h00;
        end else begin
            rx_phase = PH_DATA;
            rx_count = rx_count + 8'd1;
        end
        return 1'b1;
    endfunction

    // Advance the deframer by one line byte; return 1 when it owes a result.
    function automatic bit predict_deframe(input logic [7:0] b, output t_rx_result r);
        logic [15:0] rx_fcs;
        r.kind  = KIND_BYTE;
        r.data  = 8'h00;
        r.index = 8'h00;
        case (rx_phase)
            PH_DATA: begin
                // Unescaped flag in the payload: abort and start over at once.
                if (b == FLAG_BYTE) begin
                    r.kind = KIND_ABORT;
                    open_frame();
                    return 1'b1;
                end
                if (b == ESC_BYTE) begin
                    rx_phase = PH_ESC;
                    return 1'b0;
                end
                return take_payload(b, r);
            end
            // The byte after an escape is always data, flag or escape included.
            PH_ESC: return take_payload(b ^ ESC_MASK, r);
            // CRC bytes are raw; flag and escape mean nothing here.
            PH_CRCL: begin
                rx_crc_low = b;
                rx_phase   = PH_CRCH;
                return 1'b0;
            end
            PH_CRCH: begin
                rx_fcs   = {b, rx_crc_low};
                r.kind   = ((rx_crc ^ CRC_XOROUT) == rx_fcs) ? KIND_GOOD : KIND_BAD;
                rx_phase = PH_IDLE;
                rx_count = 8'h00;
                rx_crc   = CRC_INIT;
                return 1'b1;
            end
            default: begin
                // Idle: drop everything but the start flag.
                if (b == FLAG_BYTE) begin
                    open_frame();
                end else begin
                    rx_phase = PH_IDLE;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Offer one line byte, hold it until taken, then predict its effect.
    task automatic send_line_byte(input logic [7:0] b);
        int         gap;
        t_rx_result r;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_line_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        if (rx_phase != PH_IDLE || b == FLAG_BYTE) begin
            frame_items++;
        end
        if (predict_deframe(b, r)) begin
            frame_events_due.push_back(r);
        end
    endtask

    // Send the two CRC bytes, low first, optionally damaged.
    task automatic send_fcs(input bit corrupt);
        logic [15:0] fcs;
        fcs = rx_crc ^ CRC_XOROUT;
        if (corrupt) begin
            fcs = fcs ^ 16'($urandom_range(1, 16'hFFFF));
        end
        send_line_byte(fcs[7:0]);
        send_line_byte(fcs[15:8]);
    endtask

    // Drop valid and hold off until every owed result has come out; then let
    // a byte that causes no result clear the pipeline too.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (frame_events_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Noise before any flag, including an escape and a stuffed flag code.
    task automatic test_idle_bytes();
        logic [7:0] seq [5] = '{8'h00, 8'hFF, ESC_BYTE, FLAG_BYTE ^ ESC_MASK, ESC_MASK};
        steady_flow = 1'b0;
        foreach (seq[i]) send_line_byte(seq[i]);
        wait_drain();
    endtask

    // Back-to-back good frame: byte extremes, stuffed flag and escape,
    // escape followed by a raw flag or escape, escaped ordinary byte.
    task automatic test_good_frame();
        logic [7:0] seq [22] = '{
            FLAG_BYTE, 8'h00, 8'hFF,
            ESC_BYTE, 8'h5E, ESC_BYTE, 8'h5D,
            ESC_BYTE, FLAG_BYTE, ESC_BYTE, ESC_BYTE,
            ESC_BYTE, 8'h00,
            8'h01, 8'h80, 8'h55, 8'hAA, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
        steady_flow = 1'b1;
        foreach (seq[i]) send_line_byte(seq[i]);
        send_fcs(1'b0);
        wait_drain();
    endtask

    // Flag right after flag, flag mid-payload, then a full frame whose CRC
    // bytes are the raw flag and escape codes (a checksum mismatch).
    task automatic test_abort_and_bad_fcs();
        logic [7:0] seq [23] = '{
            FLAG_BYTE, FLAG_BYTE, 8'h11, 8'h22, FLAG_BYTE,
            8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01,
            8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F,
            FLAG_BYTE, ESC_BYTE};
        steady_flow = 1'b0;
        foreach (seq[i]) send_line_byte(seq[i]);
        wait_drain();
    endtask

    // Mostly well-formed frames with random content and stuffing, some with
    // a damaged CRC; the rest truncated frames and raw line noise.
    task automatic test_random_frames();
        int         pick;
        int         esc_pct;
        int         frames;
        logic [7:0] pay;
        frames = 0;
        while (frame_items < ITEM_TARGET) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                esc_pct = ($urandom_range(0, 3) == 0) ? 50 : 5;
                send_line_byte(FLAG_BYTE);
                for (int k = 0; k < FRAME_LEN; k++) begin
                    // Bias toward the codes that need or mimic stuffing.
                    case ($urandom_range(0, 9))
                        0: pay = FLAG_BYTE;
                        1: pay = ESC_BYTE;
                        2: pay = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
                        3: pay = ($urandom_range(0, 1) != 0) ? (FLAG_BYTE ^ ESC_MASK)
                                                             : (ESC_BYTE ^ ESC_MASK);
                        default: pay = 8'($urandom_range(0, 255));
                    endcase
                    if (pay == FLAG_BYTE || pay == ESC_BYTE
                            || $urandom_range(0, 99) < esc_pct) begin
                        send_line_byte(ESC_BYTE);
                        send_line_byte(pay ^ ESC_MASK);
                    end else begin
                        send_line_byte(pay);
                    end
                end
                send_fcs($urandom_range(0, 3) == 0);
            end else if (pick == 8) begin
                // Cut a frame short; the next flag aborts it.
                send_line_byte(FLAG_BYTE);
                repeat ($urandom_range(0, FRAME_LEN - 1)) begin
                    send_line_byte(8'($urandom_range(0, 255)));
                end
            end else begin
                repeat ($urandom_range(1, 6)) send_line_byte(8'($urandom_range(0, 255)));
            end
            frames++;
            if (frames % 40 == 0) begin
                wait_drain();
            end
        end
        wait_drain();
    endtask

    // Result side: stall a random number of cycles before taking each item.
    initial begin : result_sink
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Compare every accepted result with the oldest owed one.
    always @(posedge i_clk) begin : result_check
        t_rx_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_events_due.size() == 0) begin
                $display("%0t ns: unexpected result kind=%0d byte=%02h index=%0d",
                         $time, o_kind, o_payload_byte, o_byte_index);
                mismatches++;
            end else begin
                want = frame_events_due.pop_front();
                if ({o_kind, o_payload_byte, o_byte_index} !== want) begin
                    $display("%0t ns: expected kind=%0d byte=%02h index=%0d, got kind=%0d byte=%02h index=%0d",
                             $time, want.kind, want.data, want.index,
                             o_kind, o_payload_byte, o_byte_index);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        rx_phase   = PH_IDLE;
        rx_count   = 8'h00;
        rx_crc     = CRC_INIT;
        rx_crc_low = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_bytes();
        test_good_frame();
        test_abort_and_bad_fcs();
        test_random_frames();

        // Catch any stray result after the last one owed.
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);
        if (mismatches == 0 && frame_events_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t ns: timeout", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
